// File: hw/rtl/covariant_laplacian_stencil_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the covariant Laplacian stencil
// Shared property forms used by the top-level checks.
// ----------------------------------------------------------------------------
`ifndef COVARIANT_LAPLACIAN_STENCIL_TOP_DEFINES_SVH
`define COVARIANT_LAPLACIAN_STENCIL_TOP_DEFINES_SVH

// same-cycle implication
`define CLS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg
// Shared codes, widths and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package cls_pkg;

  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 15;
  localparam int WORD_W     = 32;
  localparam int ROW_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // largest lattice extent; store depths follow it, the address and row widths are fixed
  localparam int MAX_EXTENT = 8;

  localparam logic [CFG_DATA_W-1:0] EXT_RESET = 4'd8;

  // link layout: 72 words per site pair, 9 words per slot, first link slot 2
  localparam int SLOT_WORDS = 9;
  localparam int SITE_WORDS = 72;
  localparam int SLOT_FIRST = 2;

  localparam logic [2:0] HOP_LAST   = 3'd5;
  localparam logic [1:0] COLOR_LAST = 2'd2;

  // drain counter: the controller waits in S_DRAIN after the last term issue until the accumulator holds it
  localparam int DRAIN_W = 3;
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = 3'd6;

  typedef enum logic [CMD_W-1:0] {
    CMD_LINK  = 2'd0,
    CMD_FIELD = 2'd1,
    CMD_ROW   = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOW   = 2'd0,
    CFG_MID    = 2'd1,
    CFG_FAST   = 2'd2,
    CFG_PARITY = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_PLANE = 2'd0,
    DIV_LINE  = 2'd1,
    DIV_COLOR = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic       wr_link;
    logic       wr_field;
    logic       load;
    logic       div_step;
    div_sel_e   div_sel;
    logic       issue;
    logic       diag;
    logic [2:0] hop;
    logic [1:0] k;
    logic       finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic row_ok;
    logic ge;
    logic out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/cls_channels_if.sv
// ----------------------------------------------------------------------------
// cls channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface cls_in_if;
  import cls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [ADDR_W-1:0]        address;
  logic signed [WORD_W-1:0] value_re;
  logic signed [WORD_W-1:0] value_im;

  modport source (output valid, command, address, value_re, value_im, input ready);
  modport sink   (input valid, command, address, value_re, value_im, output ready);
endinterface

interface cls_out_if;
  import cls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] result_re;
  logic signed [WORD_W-1:0] result_im;
  logic [ROW_W-1:0]         row_out;
  logic                     saturated;

  modport source (output valid, result_re, result_im, row_out, saturated, input ready);
  modport sink   (input valid, result_re, result_im, row_out, saturated, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cls_ctrl.sv
// ----------------------------------------------------------------------------
// cls_ctrl
// Sequencer: row decode, term issue, pipeline drain and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [cls_pkg::CMD_W-1:0]     in_command_i,
  output logic                          in_ready_o,
  input  cls_pkg::ctrl_stat_t           stat_i,
  output cls_pkg::ctrl_cmd_t            cmd_o
);
  import cls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV1, S_DIV2, S_DIV3, S_DIAG, S_HOP, S_DRAIN, S_DONE
  } state_e;

  state_e             state_q;
  logic [2:0]         hop_q;
  logic [1:0]         k_q;
  logic [DRAIN_W-1:0] drain_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DIV_PLANE;
    cmd_o.hop = hop_q;
    cmd_o.k = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_command_i)
            CMD_LINK:  cmd_o.wr_link = 1'b1;
            CMD_FIELD: cmd_o.wr_field = 1'b1;
            CMD_ROW:   cmd_o.load = 1'b1;
            default:   ;
          endcase
        end
      end
      S_DIV1: begin
        cmd_o.div_sel = DIV_PLANE;
        cmd_o.div_step = stat_i.ge;
      end
      S_DIV2: begin
        cmd_o.div_sel = DIV_LINE;
        cmd_o.div_step = stat_i.ge;
      end
      S_DIV3: begin
        cmd_o.div_sel = DIV_COLOR;
        cmd_o.div_step = stat_i.ge;
      end
      S_DIAG: begin
        cmd_o.issue = 1'b1;
        cmd_o.diag = 1'b1;
      end
      S_HOP:   cmd_o.issue = 1'b1;
      S_DONE:  cmd_o.finish = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hop_q <= '0;
      k_q <= '0;
      drain_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && (in_command_i == CMD_ROW)) state_q <= S_CHECK;
        end
        S_CHECK: state_q <= stat_i.row_ok ? S_DIV1 : S_IDLE;
        S_DIV1:  if (!stat_i.ge) state_q <= S_DIV2;
        S_DIV2:  if (!stat_i.ge) state_q <= S_DIV3;
        S_DIV3:  if (!stat_i.ge) state_q <= S_DIAG;
        S_DIAG: begin
          hop_q <= '0;
          k_q <= '0;
          state_q <= S_HOP;
        end
        S_HOP: begin
          if (k_q == COLOR_LAST) begin
            k_q <= '0;
            if (hop_q == HOP_LAST) begin
              drain_q <= '0;
              state_q <= S_DRAIN;
            end else begin
              hop_q <= hop_q + 3'd1;
            end
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        S_DRAIN: begin
          if (drain_q == DRAIN_LAST) state_q <= S_DONE;
          else drain_q <= drain_q + DRAIN_W'(1);
        end
        S_DONE:  if (stat_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cls_dp.sv
// ----------------------------------------------------------------------------
// cls_dp
// Field/link stores, row decoder, address pipeline, complex MAC, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_dp #(
  parameter int FRAC_BITS  = 24
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  cls_pkg::ctrl_cmd_t                          cmd_i,
  output cls_pkg::ctrl_stat_t                         stat_o,
  input  logic [cls_pkg::ADDR_W-1:0]                  in_address_i,
  input  logic signed [cls_pkg::WORD_W-1:0]           in_value_re_i,
  input  logic signed [cls_pkg::WORD_W-1:0]           in_value_im_i,
  input  logic [$clog2(cls_pkg::MAX_EXTENT+1)-1:0]    n1_i,
  input  logic [$clog2(cls_pkg::MAX_EXTENT+1)-1:0]    n2_i,
  input  logic [$clog2(cls_pkg::MAX_EXTENT+1)-1:0]    n3_i,
  input  logic                                        parity_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic signed [cls_pkg::WORD_W-1:0]           out_re_o,
  output logic signed [cls_pkg::WORD_W-1:0]           out_im_o,
  output logic [cls_pkg::ROW_W-1:0]                   out_row_o,
  output logic                                        out_sat_o
);
  import cls_pkg::*;

  localparam int EW          = $clog2(MAX_EXTENT + 1);
  localparam int CW          = $clog2(MAX_EXTENT);
  localparam int T2W         = $clog2(MAX_EXTENT * MAX_EXTENT);
  localparam int T3W         = $clog2(MAX_EXTENT * MAX_EXTENT * MAX_EXTENT);
  localparam int FIELD_DEPTH = 3 * MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;
  localparam int LINK_DEPTH  = 36 * MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;
  localparam int FAW         = $clog2(FIELD_DEPTH);
  localparam int LAW         = $clog2(LINK_DEPTH);
  localparam int TW          = $clog2(FIELD_DEPTH + 1);
  localparam int CMPW        = (TW > ADDR_W) ? TW : ADDR_W;
  localparam int AW          = 70 - FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic valid;
    logic diag;
    logic neg;
  } tag_t;

  // ---------------- stores ----------------
  logic [2*WORD_W-1:0] field_mem [FIELD_DEPTH];
  logic [2*WORD_W-1:0] link_mem  [LINK_DEPTH];
  logic [FAW-1:0]      faddr_q;
  logic [LAW-1:0]      laddr_q;
  logic [2*WORD_W-1:0] fdat_q, ldat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_field && (32'(in_address_i) < FIELD_DEPTH)) begin
      field_mem[FAW'(in_address_i)] <= {in_value_im_i, in_value_re_i};
    end
    fdat_q <= field_mem[faddr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_link && (32'(in_address_i) < LINK_DEPTH)) begin
      link_mem[LAW'(in_address_i)] <= {in_value_im_i, in_value_re_i};
    end
    ldat_q <= link_mem[laddr_q];
  end

  // ---------------- geometry and row decode ----------------
  logic [CMPW-1:0] line_c, plane_c, total_c;
  logic [CMPW-1:0] line_q, plane_q, total_q;
  logic [CMPW-1:0] rem_q, div_c;
  logic [ADDR_W-1:0] row_q;
  logic [CW-1:0] x1_q, x2_q, x3_q;
  logic [1:0] c_w;
  logic odd_w;

  assign line_c  = (CMPW'(n3_i) << 1) + CMPW'(n3_i);
  assign plane_c = line_c * CMPW'(n2_i);
  assign total_c = line_c * (CMPW'(n2_i) * CMPW'(n1_i));

  always_ff @(posedge clk_i) begin
    line_q  <= line_c;
    plane_q <= plane_c;
    total_q <= total_c;
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_PLANE: div_c = plane_q;
      DIV_LINE:  div_c = line_q;
      default:   div_c = CMPW'(3);
    endcase
  end

  assign c_w   = rem_q[1:0];
  assign odd_w = x1_q[0] ^ x2_q[0] ^ x3_q[0] ^ parity_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= CMPW'(in_address_i);
      row_q <= in_address_i;
      x1_q <= '0;
      x2_q <= '0;
      x3_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_q - div_c;
      case (cmd_i.div_sel)
        DIV_PLANE: x1_q <= x1_q + CW'(1);
        DIV_LINE:  x2_q <= x2_q + CW'(1);
        default:   x3_q <= x3_q + CW'(1);
      endcase
    end
  end

  // ---------------- address pipeline ----------------
  function automatic logic [CW-1:0] dec_wrap(input logic [CW-1:0] x, input logic [EW-1:0] n);
    return (x == '0) ? CW'(n - EW'(1)) : x - CW'(1);
  endfunction

  function automatic logic [CW-1:0] inc_wrap(input logic [CW-1:0] x, input logic [EW-1:0] n);
    return ((EW'(x) + EW'(1)) < n) ? x + CW'(1) : '0;
  endfunction

  logic [CW-1:0] y1_c, y2_c, y3_c;
  logic          neg_c;
  logic [2:0]    slot_c;
  logic [3:0]    elem_c;

  always_comb begin
    y1_c = x1_q;
    y2_c = x2_q;
    y3_c = x3_q;
    case (cmd_i.hop)
      3'd0:    y1_c = dec_wrap(x1_q, n1_i);
      3'd1:    y1_c = inc_wrap(x1_q, n1_i);
      3'd2:    y2_c = dec_wrap(x2_q, n2_i);
      3'd3:    y2_c = inc_wrap(x2_q, n2_i);
      3'd4:    y3_c = dec_wrap(x3_q, n3_i);
      default: y3_c = inc_wrap(x3_q, n3_i);
    endcase
    neg_c  = ~cmd_i.hop[0];
    slot_c = 3'(SLOT_FIRST) + (odd_w ? (cmd_i.hop ^ 3'd1) : cmd_i.hop);
    // negative hops take the conjugate transpose element
    elem_c = neg_c ? ({2'b00, c_w} + ({2'b00, cmd_i.k} << 1) + {2'b00, cmd_i.k})
                   : (({2'b00, c_w} << 1) + {2'b00, c_w} + {2'b00, cmd_i.k});
  end

  tag_t          t0_q, t1_q, t2_q, t3_q, t4_q, t5_q;
  logic [CW-1:0] y1_q, y2_q, y3_q, b1_q, b2_q, b3_q, y3p_q, b3p_q;
  logic [2:0]    slot0_q, slot1_q, slot2_q;
  logic [3:0]    elem0_q, elem1_q, elem2_q;
  logic [1:0]    k0_q, k1_q, k2_q;
  logic [T2W-1:0] tf_q, tl_q;
  logic [T3W-1:0] fs_q, ls_q;
  logic [T3W+1:0] fidx_c;
  logic [T3W+6:0] lidx_c;
  logic [EW-1:0]  h3_w;

  assign h3_w = n3_i >> 1;
  assign fidx_c = ({2'b00, fs_q} << 1) + {2'b00, fs_q} + (T3W+2)'(k2_q);
  assign lidx_c = (T3W+7)'(ls_q) * (T3W+7)'(SITE_WORDS)
                + (T3W+7)'(slot2_q) * (T3W+7)'(SLOT_WORDS) + (T3W+7)'(elem2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_q <= '0;
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
      t4_q <= '0;
      t5_q <= '0;
    end else begin
      t0_q <= '{valid: cmd_i.issue, diag: cmd_i.diag, neg: neg_c};
      t1_q <= t0_q;
      t2_q <= t1_q;
      t3_q <= t2_q;
      t4_q <= t3_q;
      t5_q <= t4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 0: neighbor and link-site coordinates
    y1_q <= y1_c;
    y2_q <= y2_c;
    y3_q <= y3_c;
    b1_q <= odd_w ? x1_q : y1_c;
    b2_q <= odd_w ? x2_q : y2_c;
    b3_q <= odd_w ? x3_q : y3_c;
    slot0_q <= slot_c;
    elem0_q <= elem_c;
    k0_q <= cmd_i.k;
    // stage 1
    tf_q <= T2W'(n2_i) * T2W'(y1_q) + T2W'(y2_q);
    tl_q <= T2W'(n2_i) * T2W'(b1_q) + T2W'(b2_q);
    y3p_q <= y3_q;
    b3p_q <= b3_q;
    slot1_q <= slot0_q;
    elem1_q <= elem0_q;
    k1_q <= k0_q;
    // stage 2
    fs_q <= T3W'(n3_i) * T3W'(tf_q) + T3W'(y3p_q);
    ls_q <= T3W'(h3_w) * T3W'(tl_q) + T3W'(b3p_q >> 1);
    slot2_q <= slot1_q;
    elem2_q <= elem1_q;
    k2_q <= k1_q;
    // stage 3: store read addresses
    faddr_q <= t2_q.diag ? FAW'(row_q) : FAW'(fidx_c);
    laddr_q <= LAW'(lidx_c);
  end

  // ---------------- complex multiply-accumulate ----------------
  logic signed [WORD_W-1:0] fa_w, fb_w, lr_w, li_w, fa_q, fb_q;
  logic signed [63:0] p_ac_q, p_bd_q, p_ad_q, p_bc_q;
  logic signed [63:0] pbd_c, pad_c;
  logic signed [AW-1:0] tre_q, tim_q, acc_re_q, acc_im_q, fa_x, fb_x;

  assign fa_w = fdat_q[WORD_W-1:0];
  assign fb_w = fdat_q[2*WORD_W-1:WORD_W];
  assign lr_w = ldat_q[WORD_W-1:0];
  assign li_w = ldat_q[2*WORD_W-1:WORD_W];

  function automatic logic signed [AW-1:0] rnd(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + HALF;
    return AW'(s >>> FRAC_BITS);
  endfunction

  assign pbd_c = t5_q.neg ? -p_bd_q : p_bd_q;
  assign pad_c = t5_q.neg ? -p_ad_q : p_ad_q;
  assign fa_x  = AW'(fa_q);
  assign fb_x  = AW'(fb_q);

  always_ff @(posedge clk_i) begin
    p_ac_q <= fa_w * lr_w;
    p_bd_q <= fb_w * li_w;
    p_ad_q <= fa_w * li_w;
    p_bc_q <= fb_w * lr_w;
    fa_q <= fa_w;
    fb_q <= fb_w;
    if (t5_q.diag) begin
      tre_q <= -((fa_x <<< 2) + (fa_x <<< 1));
      tim_q <= -((fb_x <<< 2) + (fb_x <<< 1));
    end else begin
      tre_q <= rnd(p_ac_q) - rnd(pbd_c);
      tim_q <= rnd(pad_c) + rnd(p_bc_q);
    end
  end

  tag_t t6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t6_q <= '0;
    else t6_q <= t5_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (t6_q.valid) begin
      acc_re_q <= acc_re_q + tre_q;
      acc_im_q <= acc_im_q + tim_q;
    end
  end

  // ---------------- saturation and result register ----------------
  logic sat_re_w, sat_im_w;
  logic signed [WORD_W-1:0] clip_re_w, clip_im_w;

  assign sat_re_w = !((&acc_re_q[AW-1:WORD_W-1]) || !(|acc_re_q[AW-1:WORD_W-1]));
  assign sat_im_w = !((&acc_im_q[AW-1:WORD_W-1]) || !(|acc_im_q[AW-1:WORD_W-1]));
  assign clip_re_w = sat_re_w ? {acc_re_q[AW-1], {(WORD_W-1){~acc_re_q[AW-1]}}}
                              : acc_re_q[WORD_W-1:0];
  assign clip_im_w = sat_im_w ? {acc_im_q[AW-1], {(WORD_W-1){~acc_im_q[AW-1]}}}
                              : acc_im_q[WORD_W-1:0];

  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.finish) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_re_o  <= clip_re_w;
      out_im_o  <= clip_im_w;
      out_row_o <= row_q[ROW_W-1:0];
      out_sat_o <= sat_re_w | sat_im_w;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.ge       = rem_q >= div_c;
  assign stat_o.row_ok   = rem_q < total_q;

endmodule

`default_nettype wire

// File: hw/rtl/covariant_laplacian_stencil_top.sv
// Covariant Laplacian stencil, three colors on a periodic 3-D lattice. Link
// and field write items are accepted while idle and keep the block idle. A
// compute item blocks new items until its row is rejected or its result is
// registered: the row is split into coordinates by a compare-and-subtract
// decoder, one step per cycle, then the diagonal and 18 hop/color terms are
// issued one per cycle, since each store has a single read port, into an
// address, read, multiply, round and accumulate pipeline. The result is held
// in an output register, so the next item is accepted while it waits to be taken.
`default_nettype none

`include "covariant_laplacian_stencil_top_defines.svh"

// ----------------------------------------------------------------------------
// covariant_laplacian_stencil_top
// Configuration registers, extent clamping, controller and datapath.
// ----------------------------------------------------------------------------
module covariant_laplacian_stencil_top #(
  parameter int FRAC_BITS  = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cls_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cls_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  cls_in_if.sink                             in_i,
  cls_out_if.source                          out_o
);
  import cls_pkg::*;

  localparam int EW = $clog2(MAX_EXTENT + 1);

  logic [CFG_DATA_W-1:0] ext_slow_q, ext_mid_q, ext_fast_q;
  logic                  parity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_slow_q <= EXT_RESET;
      ext_mid_q <= EXT_RESET;
      ext_fast_q <= EXT_RESET;
      parity_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLOW:   ext_slow_q <= cfg_data_i;
        CFG_MID:    ext_mid_q <= cfg_data_i;
        CFG_FAST:   ext_fast_q <= cfg_data_i;
        CFG_PARITY: parity_q <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  function automatic logic [EW-1:0] clamp_ext(input logic [CFG_DATA_W-1:0] raw);
    if (raw < CFG_DATA_W'(2)) return EW'(2);
    else if (int'(raw) > MAX_EXTENT) return EW'(MAX_EXTENT);
    else return EW'(raw);
  endfunction

  logic [EW-1:0] n1_w, n2_w, n3_raw_w, n3_w;
  assign n1_w     = clamp_ext(ext_slow_q);
  assign n2_w     = clamp_ext(ext_mid_q);
  assign n3_raw_w = clamp_ext(ext_fast_q);
  assign n3_w     = {n3_raw_w[EW-1:1], 1'b0};

  ctrl_cmd_t  cmd_w;
  ctrl_stat_t stat_w;

  cls_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .stat_i       (stat_w),
    .cmd_o        (cmd_w)
  );

  cls_dp #(
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_w),
    .stat_o        (stat_w),
    .in_address_i  (in_i.address),
    .in_value_re_i (in_i.value_re),
    .in_value_im_i (in_i.value_im),
    .n1_i          (n1_w),
    .n2_i          (n2_w),
    .n3_i          (n3_w),
    .parity_i      (parity_q),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_re_o      (out_o.result_re),
    .out_im_o      (out_o.result_im),
    .out_row_o     (out_o.row_out),
    .out_sat_o     (out_o.saturated)
  );

  `CLS_ASSERT_NOW(a_no_issue_when_ready, clk_i, rst_ni, in_i.ready, !cmd_w.issue, "term issued while idle")
  `CLS_ASSERT_NOW(a_step_needs_ge, clk_i, rst_ni, cmd_w.div_step, stat_w.ge, "decoder step below divisor")
  `CLS_ASSERT_NEXT(a_finish_sets_valid, clk_i, rst_ni, cmd_w.finish, out_o.valid, "finished row not presented")

endmodule

`default_nettype wire
